FILE: hw/rtl/vlprq_pkg.sv
// Shared types and constants for the variable-length packet ring queue.
package vlprq_pkg;

  localparam int QUEUE_BYTES_DEF = 1024;
  localparam int PACKET_MAX_DEF  = 64;
  localparam int LEN_BYTES       = 4;   // length field size at header offset 0
  localparam int WSIZE_W         = 11;
  localparam int FILL_W          = 11;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_REJECT  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BADLEN  = 3'd4
  } status_e;

  typedef struct packed {
    logic               mode;
    logic [7:0]         data_byte;
    logic [WSIZE_W-1:0] write_size;
    logic               last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    status_e           status;
    logic [FILL_W-1:0] fill_level;
    logic              end_of_run;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic               is_pop;
    logic [7:0]         data;
    logic [WSIZE_W-1:0] size;
    logic               last;
  } cmd_t;

endpackage

FILE: hw/rtl/vlprq_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
module vlprq_front import vlprq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  cmd_t       cmd_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_new;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rd_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_new.is_pop = in_data_i.mode;
    cmd_new.data   = in_data_i.data_byte;
    cmd_new.size   = in_data_i.write_size;
    cmd_new.last   = in_data_i.last_byte;
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/vlprq_back.sv
// Back end: byte ring memory, write admission, header parse and packet streaming.
module vlprq_back import vlprq_pkg::*; #(
  parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
  parameter int PACKET_MAX  = PACKET_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int AW = $clog2(QUEUE_BYTES);
  localparam int CW = $clog2(QUEUE_BYTES + 1);
  localparam int SW = ((CW > WSIZE_W) ? CW : WSIZE_W) + 1;
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int RW = $clog2(PACKET_MAX + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_BYTES - 1);
  localparam logic [CW-1:0] FULL      = CW'(QUEUE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HDR    = 4'b0010,
    S_CHECK  = 4'b0100,
    S_STREAM = 4'b1000
  } state_e;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  logic [7:0]    mem [QUEUE_BYTES];
  logic [7:0]    rdata_q;

  state_e        state_q, state_d;
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, hp_q, hp_d;
  logic [CW-1:0] bc_q, bc_d;
  logic          wact_q, wact_d, wdrop_q, wdrop_d;
  logic [1:0]    hcnt_q, hcnt_d;
  logic [7:0]    len_q, len_d;
  logic          hinz_q, hinz_d;
  logic [RW-1:0] remain_q, remain_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, res;

  logic          re, we, emit, out_free;
  logic [AW-1:0] raddr, waddr, wp_eff;
  logic          fits, drop, restart, bad;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    hp_d        = hp_q;
    bc_d        = bc_q;
    wact_d      = wact_q;
    wdrop_d     = wdrop_q;
    hcnt_d      = hcnt_q;
    len_d       = len_q;
    hinz_d      = hinz_q;
    remain_d    = remain_q;
    re          = 1'b0;
    raddr       = rp_q;
    we          = 1'b0;
    waddr       = wp_q;
    emit        = 1'b0;
    cmd_ready_o = 1'b0;
    res         = '0;
    fits        = (SW'(bc_q) + SW'(cmd_i.size)) <= SW'(QUEUE_BYTES);
    drop        = wact_q ? wdrop_q : !fits;
    restart     = !wact_q && fits && (bc_q == '0);
    wp_eff      = restart ? '0 : wp_q;
    bad         = hinz_q || (len_q == 8'd0) || (LW'(len_q) > LW'(bc_q)) ||
                  (len_q > 8'(PACKET_MAX));

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !cmd_i.is_pop) begin
          if (out_free) begin
            if (restart) begin
              rp_d = '0;
            end
            wp_d = wp_eff;
            if (!drop && (bc_q < FULL)) begin
              we    = 1'b1;
              waddr = wp_eff;
              wp_d  = next_ptr(wp_eff);
              bc_d  = bc_q + CW'(1);
            end
            wact_d      = !cmd_i.last;
            wdrop_d     = cmd_i.last ? 1'b0 : drop;
            emit        = 1'b1;
            res.status  = drop ? ST_REJECT : ST_ACCEPT;
            res.end_of_run = 1'b1;
            cmd_ready_o = 1'b1;
          end
        end else if (cmd_valid_i) begin
          if (bc_q < CW'(LEN_BYTES)) begin
            if (out_free) begin
              emit           = 1'b1;
              res.status     = (bc_q == '0) ? ST_EMPTY : ST_BADLEN;
              res.end_of_run = 1'b1;
              cmd_ready_o    = 1'b1;
            end
          end else begin
            re      = 1'b1;
            raddr   = rp_q;
            hp_d    = next_ptr(rp_q);
            hcnt_d  = 2'd0;
            hinz_d  = 1'b0;
            state_d = S_HDR;
          end
        end
      end
      S_HDR: begin
        // one header byte lands per cycle; only byte 0 may be nonzero
        if (hcnt_q == 2'd0) begin
          len_d = rdata_q;
        end else begin
          hinz_d = hinz_q || (rdata_q != 8'd0);
        end
        if (hcnt_q == 2'(LEN_BYTES - 1)) begin
          state_d = S_CHECK;
        end else begin
          re     = 1'b1;
          raddr  = hp_q;
          hp_d   = next_ptr(hp_q);
          hcnt_d = hcnt_q + 2'd1;
        end
      end
      S_CHECK: begin
        if (bad) begin
          if (out_free) begin
            emit           = 1'b1;
            res.status     = ST_BADLEN;
            res.end_of_run = 1'b1;
            cmd_ready_o    = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          re       = 1'b1;
          raddr    = rp_q;
          rp_d     = next_ptr(rp_q);
          bc_d     = bc_q - CW'(len_q);
          remain_d = RW'(len_q);
          state_d  = S_STREAM;
        end
      end
      S_STREAM: begin
        if (out_free) begin
          emit           = 1'b1;
          res.out_byte   = rdata_q;
          res.status     = ST_BYTE;
          res.end_of_run = (remain_q == RW'(1));
          if (remain_q == RW'(1)) begin
            cmd_ready_o = 1'b1;
            state_d     = S_IDLE;
          end else begin
            re       = 1'b1;
            raddr    = rp_q;
            rp_d     = next_ptr(rp_q);
            remain_d = remain_q - RW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.fill_level = FILL_W'(bc_d);
    out_valid_d    = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cmd_i.data;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
    len_q <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      hp_q        <= '0;
      bc_q        <= '0;
      wact_q      <= 1'b0;
      wdrop_q     <= 1'b0;
      hcnt_q      <= 2'd0;
      hinz_q      <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      hp_q        <= hp_d;
      bc_q        <= bc_d;
      wact_q      <= wact_d;
      wdrop_q     <= wdrop_d;
      hcnt_q      <= hcnt_d;
      hinz_q      <= hinz_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/variable_length_packet_ring_queue.sv
// Push byte: the result is registered in the output register; 1 byte per cycle
// while the output is not stalled. Pop: header bytes are read from the single ring
// read port, the length is checked, then 1 packet byte per cycle while not stalled.
// Empty and short-fill pops answer from idle; a bad length field from the check.
// Reset clears pointers, fill count, write flags and the output valid flag;
// ring contents are undefined until written (no clearing pass).
module variable_length_packet_ring_queue import vlprq_pkg::*; #(
  parameter int QUEUE_BYTES = QUEUE_BYTES_DEF,
  parameter int PACKET_MAX  = PACKET_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  vlprq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vlprq_back #(
    .QUEUE_BYTES (QUEUE_BYTES),
    .PACKET_MAX  (PACKET_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/vlprq_checker.sv
// Port-level checks for the packet ring queue, bound to the top level.
module vlprq_checker import vlprq_pkg::*; #(
  parameter int QUEUE_BYTES = QUEUE_BYTES_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // stalled result must hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_data_i.fill_level) <= 32'(QUEUE_BYTES))
    else $error("fill level beyond ring size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ST_BYTE) |->
      (out_data_i.out_byte == 8'd0) && out_data_i.end_of_run)
    else $error("status result carries data or is not the last");

  // a reset edge leaves no result pending
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind variable_length_packet_ring_queue vlprq_checker #(
  .QUEUE_BYTES (QUEUE_BYTES)
) u_vlprq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
